// File: rtl/mts_pkg.sv
package mts_pkg;

    // Request codes carried in the kind field.
    localparam logic [2:0] KIND_ONCE       = 3'd0;
    localparam logic [2:0] KIND_REPEAT     = 3'd1;
    localparam logic [2:0] KIND_CANCEL     = 3'd2;
    localparam logic [2:0] KIND_CANCEL_ALL = 3'd3;
    localparam logic [2:0] KIND_TICK       = 3'd4;

    // Result codes carried in the result_kind field.
    localparam logic [1:0] RK_SCHED  = 2'd0;
    localparam logic [1:0] RK_CANCEL = 2'd1;
    localparam logic [1:0] RK_FIRED  = 2'd2;
    localparam logic [1:0] RK_QUIET  = 2'd3;

    // At most this many timers fire on one tick.
    localparam int MAX_RESULTS = 16;
    localparam int RB_AW       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] delay_ms;
        logic [31:0] interval_ms;
        logic [31:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] timer_id;
        logic        ok;
        logic [4:0]  active_count;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_SCAN,
        ST_UPDATE,
        ST_REPLY,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } state_t;

endpackage

// File: rtl/mts_ram.sv
module mts_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/mts_engine.sv
module mts_engine #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 48
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               enabled,
    input  logic               s_valid,
    output logic               s_ready,
    input  mts_pkg::in_item_t  s_item,
    output logic               res_valid,
    input  logic               res_ready,
    output mts_pkg::out_item_t res_item
);

    import mts_pkg::*;

    localparam int IW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW  = $clog2(NUM_TIMERS + 1);
    localparam int TW  = TIME_WIDTH;
    localparam int EW  = 32 + TW + 32 + 1;
    localparam logic [IW:0]    ISSUE_END = (IW + 1)'(NUM_TIMERS);
    localparam logic [IW-1:0]  LAST_IDX  = IW'(NUM_TIMERS - 1);
    localparam logic [RB_AW:0] FIRE_STOP = (RB_AW + 1)'(MAX_RESULTS - 1);

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t, input logic [31:0] d);
        logic [TW:0] sum;
        sum = {1'b0, t} + {{(TW + 1 - 32){1'b0}}, d};
        if (sum[TW]) begin
            return {TW{1'b1}};
        end
        return sum[TW-1:0];
    endfunction

    state_t state_reg, state_next;

    in_item_t         item_reg;
    logic [NUM_TIMERS-1:0] valid_reg;
    logic [NUM_TIMERS-1:0] pending_reg;
    logic [CW-1:0]    count_reg;
    logic [TW-1:0]    time_reg;
    logic [31:0]      next_id_reg;
    logic [IW:0]      issue_reg;
    logic             cmp_valid_reg;
    logic [IW-1:0]    cmp_idx_reg;
    logic             first_pass_reg;
    logic             best_found_reg;
    logic [IW-1:0]    best_idx_reg;
    logic [31:0]      best_id_reg;
    logic [31:0]      best_period_reg;
    logic             best_rep_reg;
    logic [RB_AW:0]   fired_cnt_reg;
    logic [RB_AW-1:0] drain_idx_reg;
    logic [1:0]       reply_kind_reg;
    logic [31:0]      reply_id_reg;
    logic             reply_ok_reg;

    // Slot memory and fired-id buffer ports.
    logic             slot_we;
    logic [IW-1:0]    slot_waddr;
    logic [EW-1:0]    slot_wdata;
    logic             slot_re;
    logic [IW-1:0]    slot_raddr;
    logic [EW-1:0]    slot_rdata;
    logic             rb_we;
    logic             rb_re;
    logic [31:0]      rb_rdata;

    logic [31:0]      rd_id;
    logic [TW-1:0]    rd_deadline;
    logic [31:0]      rd_period;
    logic             rd_rep;

    logic [IW-1:0]    free_idx;
    logic             table_full;
    logic             sched_rep;
    logic             sched_ok;
    logic [31:0]      sched_delay;
    logic             is_cancel;
    logic             cmp_last;
    logic             cancel_hit;
    logic             tick_cand;
    logic             tick_better;
    logic [NUM_TIMERS-1:0] best_mask;
    logic             upd_stop;
    logic             drain_last;
    logic [CW+4:0]    count_ext;

    assign rd_id       = slot_rdata[EW-1 -: 32];
    assign rd_deadline = slot_rdata[TW+32:33];
    assign rd_period   = slot_rdata[32:1];
    assign rd_rep      = slot_rdata[0];

    // Lowest free slot.
    always_comb begin
        free_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            best_mask[i] = (best_idx_reg == IW'(i));
        end
    end

    assign table_full  = &valid_reg;
    assign sched_rep   = (item_reg.kind == KIND_REPEAT);
    assign sched_ok    = enabled && !table_full && !(sched_rep && item_reg.interval_ms == '0);
    assign sched_delay = (sched_rep && item_reg.delay_ms == '0) ? item_reg.interval_ms
                                                                 : item_reg.delay_ms;
    assign is_cancel   = (item_reg.kind == KIND_CANCEL);
    assign cmp_last    = (cmp_idx_reg == LAST_IDX);
    assign cancel_hit  = valid_reg[cmp_idx_reg] && (rd_id == item_reg.target_id);
    // The first pass of a tick decides which slots are due; later passes reuse that set.
    assign tick_cand   = first_pass_reg ? (valid_reg[cmp_idx_reg] && rd_deadline <= time_reg)
                                        : pending_reg[cmp_idx_reg];
    assign tick_better = tick_cand && (!best_found_reg || rd_id < best_id_reg);
    assign upd_stop    = (fired_cnt_reg == FIRE_STOP) || ((pending_reg & ~best_mask) == '0);
    assign drain_last  = ((RB_AW + 1)'(drain_idx_reg) + (RB_AW + 1)'(1)) == fired_cnt_reg;
    assign count_ext   = {5'd0, count_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_item.kind)
                        KIND_ONCE, KIND_REPEAT: state_next = ST_SCHED;
                        KIND_CANCEL, KIND_TICK: state_next = ST_SCAN;
                        KIND_CANCEL_ALL:        state_next = ST_REPLY;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCHED: state_next = ST_REPLY;
            ST_SCAN: begin
                if (cmp_valid_reg) begin
                    if (is_cancel) begin
                        if (cancel_hit || cmp_last) begin
                            state_next = ST_REPLY;
                        end
                    end else if (cmp_last) begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                if (!best_found_reg) begin
                    state_next = ST_REPLY;
                end else if (upd_stop) begin
                    state_next = ST_DRAIN_RD;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_REPLY: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_RD: state_next = ST_DRAIN_OUT;
            ST_DRAIN_OUT: begin
                if (res_ready) begin
                    state_next = drain_last ? ST_IDLE : ST_DRAIN_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        res_valid  = 1'b0;
        res_item   = '{result_kind: reply_kind_reg, timer_id: reply_id_reg, ok: reply_ok_reg,
                       active_count: count_ext[4:0], last: 1'b1};
        slot_we    = 1'b0;
        slot_waddr = free_idx;
        slot_wdata = {next_id_reg, sat_add(time_reg, sched_delay),
                      sched_rep ? item_reg.interval_ms : 32'd0, sched_rep};
        slot_re    = 1'b0;
        slot_raddr = issue_reg[IW-1:0];
        rb_we      = 1'b0;
        rb_re      = 1'b0;
        unique case (state_reg)
            ST_SCHED: slot_we = sched_ok;
            ST_SCAN:  slot_re = (issue_reg != ISSUE_END);
            ST_UPDATE: begin
                rb_we      = best_found_reg;
                slot_we    = best_found_reg && best_rep_reg;
                slot_waddr = best_idx_reg;
                slot_wdata = {best_id_reg, sat_add(time_reg, best_period_reg),
                              best_period_reg, 1'b1};
            end
            ST_REPLY: res_valid = 1'b1;
            ST_DRAIN_RD: rb_re = 1'b1;
            ST_DRAIN_OUT: begin
                res_valid = 1'b1;
                res_item  = '{result_kind: RK_FIRED, timer_id: rb_rdata, ok: 1'b1,
                              active_count: count_ext[4:0], last: drain_last};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            pending_reg    <= '0;
            count_reg      <= '0;
            time_reg       <= '0;
            next_id_reg    <= 32'd1;
            issue_reg      <= '0;
            cmp_valid_reg  <= 1'b0;
            first_pass_reg <= 1'b0;
            best_found_reg <= 1'b0;
            fired_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    issue_reg      <= '0;
                    cmp_valid_reg  <= 1'b0;
                    best_found_reg <= 1'b0;
                    first_pass_reg <= 1'b1;
                    fired_cnt_reg  <= '0;
                    if (s_valid && s_item.kind == KIND_CANCEL_ALL) begin
                        valid_reg <= '0;
                        count_reg <= '0;
                    end
                    if (s_valid && s_item.kind == KIND_TICK) begin
                        time_reg    <= sat_add(time_reg, 32'd1);
                        pending_reg <= '0;
                    end
                end
                ST_SCHED: begin
                    if (sched_ok) begin
                        valid_reg[free_idx] <= 1'b1;
                        count_reg           <= count_reg + CW'(1);
                        next_id_reg         <= (next_id_reg == '1) ? 32'd1 : next_id_reg + 32'd1;
                    end
                end
                ST_SCAN: begin
                    if (issue_reg != ISSUE_END) begin
                        issue_reg     <= issue_reg + (IW + 1)'(1);
                        cmp_valid_reg <= 1'b1;
                    end else begin
                        cmp_valid_reg <= 1'b0;
                    end
                    if (cmp_valid_reg) begin
                        if (is_cancel) begin
                            if (cancel_hit) begin
                                valid_reg[cmp_idx_reg] <= 1'b0;
                                count_reg              <= count_reg - CW'(1);
                            end
                        end else begin
                            if (first_pass_reg) begin
                                pending_reg[cmp_idx_reg] <= tick_cand;
                            end
                            if (tick_better) begin
                                best_found_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_UPDATE: begin
                    if (best_found_reg) begin
                        pending_reg[best_idx_reg] <= 1'b0;
                        fired_cnt_reg             <= fired_cnt_reg + (RB_AW + 1)'(1);
                        if (!best_rep_reg) begin
                            valid_reg[best_idx_reg] <= 1'b0;
                            count_reg               <= count_reg - CW'(1);
                        end
                        issue_reg      <= '0;
                        cmp_valid_reg  <= 1'b0;
                        best_found_reg <= 1'b0;
                        first_pass_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg <= s_item;
        end
        if (state_reg == ST_SCAN && issue_reg != ISSUE_END) begin
            cmp_idx_reg <= issue_reg[IW-1:0];
        end
        if (state_reg == ST_SCAN && cmp_valid_reg && !is_cancel && tick_better) begin
            best_idx_reg    <= cmp_idx_reg;
            best_id_reg     <= rd_id;
            best_period_reg <= rd_period;
            best_rep_reg    <= rd_rep;
        end
        if (state_reg == ST_UPDATE) begin
            drain_idx_reg <= '0;
        end else if (state_reg == ST_DRAIN_OUT && res_ready) begin
            drain_idx_reg <= drain_idx_reg + RB_AW'(1);
        end
        unique case (state_reg)
            ST_IDLE: begin
                reply_kind_reg <= RK_CANCEL;
                reply_id_reg   <= '0;
                reply_ok_reg   <= 1'b1;
            end
            ST_SCHED: begin
                reply_kind_reg <= RK_SCHED;
                reply_id_reg   <= sched_ok ? next_id_reg : 32'd0;
                reply_ok_reg   <= sched_ok;
            end
            ST_SCAN: begin
                reply_kind_reg <= RK_CANCEL;
                reply_id_reg   <= item_reg.target_id;
                reply_ok_reg   <= cancel_hit;
            end
            ST_UPDATE: begin
                reply_kind_reg <= RK_QUIET;
                reply_id_reg   <= '0;
                reply_ok_reg   <= 1'b0;
            end
            default: ;
        endcase
    end

    mts_ram #(
        .DEPTH (NUM_TIMERS),
        .WIDTH (EW),
        .AW    (IW)
    ) u_slot_mem (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    mts_ram #(
        .DEPTH (MAX_RESULTS),
        .WIDTH (32),
        .AW    (RB_AW)
    ) u_fire_buf (
        .aclk  (aclk),
        .we    (rb_we),
        .waddr (fired_cnt_reg[RB_AW-1:0]),
        .wdata (best_id_reg),
        .re    (rb_re),
        .raddr (drain_idx_reg),
        .rdata (rb_rdata)
    );

endmodule

// File: rtl/multi_timer_scheduler.sv
// Timer table with NUM_TIMERS slots held in a single-port-read slot memory. Every request
// of a known kind is one transfer in and one or more result transfers out; a request with
// an unused kind code gets no result. The block takes one request at a time. A cancel
// walks the slot memory one entry per cycle and answers at the first matching entry or
// after the last one. A tick walks the whole table once per timer that fires (firing the
// lowest id found in each pass, at most 16 per tick), then reads each fired id from the
// fired-id buffer and sends it; a tick with nothing due makes a single pass and answers
// with a quiet result. The scans go through the slot memory read port. A finished result
// waits in an output register, so the next request is taken while the last result of the
// previous one is still held.
module multi_timer_scheduler #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 48
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  mts_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output mts_pkg::out_item_t m_item
);

    import mts_pkg::*;

    logic      enabled_reg;
    logic      m_valid_reg;
    out_item_t m_item_reg;
    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            enabled_reg <= cfg_wr_data;
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    mts_engine #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enabled   (enabled_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

`ifndef SYNTHESIS
    // The engine never offers a result while it is waiting for a request.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("result offered while idle");

    // Fired timers always carry a real id.
    a_fired_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_item.result_kind == RK_FIRED) |->
            (res_item.timer_id != 32'd0 && res_item.ok))
        else $error("fired result without a valid id");

    // A rejected schedule answers with id zero; an accepted one never does.
    a_sched_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_item.result_kind == RK_SCHED) |->
            (res_item.ok == (res_item.timer_id != 32'd0)))
        else $error("schedule reply id does not match its status");

    // Single-result replies close their request.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_item.result_kind != RK_FIRED) |-> res_item.last)
        else $error("single reply not marked last");
`endif

endmodule

// File: test/tb_multi_timer_scheduler.sv
module tb_multi_timer_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import mts_pkg::*;

    localparam int NSLOT = 16;
    localparam int TW = 48;
    // Longest quiet stretch the block may still spend on an item that gives no result.
    localparam int SETTLE_CYCLES = 2 * NSLOT + 8;
    localparam int RANDOM_PHASES = 4;
    localparam int ITEMS_PER_PHASE = 86;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_wr_data = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b1;
    out_item_t m_item;

    // Shadow copy of the timer table.
    bit tm_live[NSLOT];
    logic [31:0] tm_id[NSLOT];
    logic [TW-1:0] tm_due[NSLOT];
    logic [31:0] tm_period[NSLOT];
    bit tm_repeat[NSLOT];
    logic [TW-1:0] now_ticks = '0;
    logic [31:0] id_next = 32'd1;
    bit enable_q = 1'b0;

    out_item_t pending_replies[$];
    out_item_t want;
    int errors = 0;
    int stall_left = 0;
    bit gaps_on = 1'b1;

    multi_timer_scheduler dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    always #5 aclk = ~aclk;

    function automatic logic [TW-1:0] sat_sum(logic [TW-1:0] t, logic [TW-1:0] d);
        logic [TW:0] s;
        s = {1'b0, t} + {1'b0, d};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (tm_live[i]) n++;
        end
        return n;
    endfunction

    // Applies one request to the shadow table and queues the replies it produces.
    task automatic predict_timer_step(input in_item_t req);
        out_item_t replies[$];
        out_item_t r;
        int slot;
        int n;
        int j;
        int cnt;
        int order[NSLOT];
        bit rep;
        bit hit;
        r = '0;
        rep = (req.kind == KIND_REPEAT);
        slot = -1;
        case (req.kind)
            KIND_ONCE, KIND_REPEAT: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tm_live[i] && slot < 0) slot = i;
                end
                r.result_kind = RK_SCHED;
                if (enable_q && slot >= 0 && !(rep && req.interval_ms == 0)) begin
                    tm_live[slot] = 1'b1;
                    tm_id[slot] = id_next;
                    tm_repeat[slot] = rep;
                    tm_period[slot] = rep ? req.interval_ms : 32'd0;
                    tm_due[slot] = sat_sum(now_ticks, (rep && req.delay_ms == 0) ?
                                           TW'(req.interval_ms) : TW'(req.delay_ms));
                    r.timer_id = id_next;
                    r.ok = 1'b1;
                    id_next = (id_next == 32'hFFFF_FFFF) ? 32'd1 : id_next + 32'd1;
                end
                replies = {replies, r};
            end
            KIND_CANCEL: begin
                hit = 1'b0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!hit && tm_live[i] && tm_id[i] == req.target_id) begin
                        tm_live[i] = 1'b0;
                        hit = 1'b1;
                    end
                end
                r.result_kind = RK_CANCEL;
                r.timer_id = req.target_id;
                r.ok = hit;
                replies = {replies, r};
            end
            KIND_CANCEL_ALL: begin
                for (int i = 0; i < NSLOT; i++) tm_live[i] = 1'b0;
                r.result_kind = RK_CANCEL;
                r.ok = 1'b1;
                replies = {replies, r};
            end
            KIND_TICK: begin
                now_ticks = sat_sum(now_ticks, TW'(1));
                n = 0;
                // Expired slots sorted by id; equal ids keep slot order.
                for (int i = 0; i < NSLOT; i++) begin
                    if (tm_live[i] && tm_due[i] <= now_ticks) begin
                        j = n;
                        while (j > 0 && tm_id[order[j-1]] > tm_id[i]) begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = i;
                        n++;
                    end
                end
                if (n > MAX_RESULTS) n = MAX_RESULTS;
                if (n == 0) begin
                    r.result_kind = RK_QUIET;
                    replies = {replies, r};
                end
                for (int k = 0; k < n; k++) begin
                    slot = order[k];
                    r.result_kind = RK_FIRED;
                    r.timer_id = tm_id[slot];
                    r.ok = 1'b1;
                    replies = {replies, r};
                    if (tm_repeat[slot])
                        tm_due[slot] = sat_sum(now_ticks, TW'(tm_period[slot]));
                    else
                        tm_live[slot] = 1'b0;
                end
            end
            default: ;
        endcase
        cnt = live_count();
        foreach (replies[k]) begin
            replies[k].active_count = 5'(cnt);
            replies[k].last = (k == replies.size() - 1);
            pending_replies = {pending_replies, replies[k]};
        end
    endtask

    function automatic in_item_t make_req(logic [2:0] kind, logic [31:0] delay,
                                          logic [31:0] interval, logic [31:0] target);
        in_item_t q;
        q.kind = kind;
        q.delay_ms = delay;
        q.interval_ms = interval;
        q.target_id = target;
        return q;
    endfunction

    function automatic in_item_t random_request();
        in_item_t q;
        int pick;
        logic [31:0] ids[$];
        q.delay_ms = $urandom;
        q.interval_ms = $urandom;
        q.target_id = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 22) q.kind = KIND_ONCE;
        else if (pick < 42) q.kind = KIND_REPEAT;
        else if (pick < 57) q.kind = KIND_CANCEL;
        else if (pick < 60) q.kind = KIND_CANCEL_ALL;
        else if (pick < 63) q.kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        else q.kind = KIND_TICK;
        // Mostly short delays and periods so timers actually expire.
        if ($urandom_range(0, 99) < 85) q.delay_ms = $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 85) q.interval_ms = $urandom_range(0, 5);
        pick = $urandom_range(0, 99);
        for (int i = 0; i < NSLOT; i++) begin
            if (tm_live[i]) ids = {ids, tm_id[i]};
        end
        if (pick < 60 && ids.size() > 0)
            q.target_id = ids[$urandom_range(0, ids.size() - 1)];
        else if (pick < 80)
            q.target_id = $urandom_range(0, id_next);
        return q;
    endfunction

    task automatic send_request(input in_item_t req);
        int gap;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_timer_step(req);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_enable(input bit value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        enable_q = value;
    endtask

    // Disabled out of reset: schedules are refused, ticks and cancels still answer.
    task automatic test_disabled_requests();
        send_request(make_req(KIND_ONCE, 32'd1, 32'd0, 32'd0));
        send_request(make_req(KIND_REPEAT, 32'd0, 32'd5, 32'd0));
        send_request(make_req(KIND_TICK, 32'd0, 32'd0, 32'd0));
        send_request(make_req(KIND_CANCEL, 32'd0, 32'd0, 32'd1));
        send_request(make_req(KIND_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // Fill every slot so that all sixteen fire on the same tick.
    task automatic test_full_table();
        send_request(make_req(KIND_REPEAT, 32'd3, 32'd0, 32'd0));
        for (int i = 0; i < NSLOT; i++) begin
            if (i == 1)
                send_request(make_req(KIND_REPEAT, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
            else if (i % 2 == 0)
                send_request(make_req(KIND_ONCE, (i == 0) ? 32'd0 : 32'd1,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
            else
                send_request(make_req(KIND_REPEAT, 32'd0, 32'd1, 32'd0));
        end
        send_request(make_req(KIND_ONCE, 32'd1, 32'd1, 32'd0));
        send_request(make_req(KIND_TICK, 32'd0, 32'd0, 32'd0));
        send_request(make_req(KIND_TICK, 32'd0, 32'd0, 32'd0));
    endtask

    task automatic test_cancel();
        send_request(make_req(KIND_CANCEL, 32'd0, 32'd0, 32'd2));
        send_request(make_req(KIND_CANCEL, 32'd0, 32'd0, 32'd1));
        send_request(make_req(KIND_CANCEL_ALL, 32'd0, 32'd0, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic();
        bit phase_enable[RANDOM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1};
        in_item_t req;
        int sent;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            write_enable(phase_enable[p]);
            gaps_on = (p != 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                req = random_request();
                send_request(req);
                if (req.kind <= KIND_TICK) sent++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Result side: check every transfer against the oldest prediction, then maybe stall.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h",
                         $time, m_item);
            end else begin
                want = pending_replies.pop_front();
                check_field("result_kind", 32'(want.result_kind), 32'(m_item.result_kind));
                check_field("timer_id", want.timer_id, m_item.timer_id);
                check_field("ok", 32'(want.ok), 32'(m_item.ok));
                check_field("active_count", 32'(want.active_count),
                            32'(m_item.active_count));
                check_field("last", 32'(want.last), 32'(m_item.last));
            end
            stall_left = gaps_on ? $urandom_range(0, 3) : 0;
            if (stall_left != 0) m_ready <= 1'b0;
        end else if (!m_ready) begin
            stall_left--;
            if (stall_left <= 0) m_ready <= 1'b1;
        end
    end

    initial begin
        for (int i = 0; i < NSLOT; i++) tm_live[i] = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_requests();
        wait_idle();
        write_enable(1'b1);
        test_full_table();
        test_cancel();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
